// ===== rtl/core/lbps_pkg.sv =====
// ----------------------------------------------------------------------------
// LED bit-pattern sequencer package
// Register indexes, field widths and the result record shared by the design.
// ----------------------------------------------------------------------------
package lbps_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned STATE_W    = 8;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 16;

    // The low three bits of the bit index pick one of the eight pattern bits.
    localparam logic [CNT_W-1:0] BIT_SEL_MASK = 8'h07;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN           = 3'd0,
        REG_TICK_PERIOD       = 3'd1,
        REG_LAST_BIT_INDEX    = 3'd2,
        REG_HOLD_TICKS        = 3'd3,
        REG_BUZZER_ENABLE     = 3'd4,
        REG_NEXT_STATE        = 3'd5,
        REG_NEXT_STATE_ENABLE = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [STATE_W-1:0] requested_state;
        logic               state_request;
        logic               buzzer_on;
        logic               red_led_on;
    } t_result;

endpackage

// ===== rtl/core/led_bit_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED bit-pattern sequencer
// Steps an eight-bit pattern onto a red LED and a buzzer, one tick per item.
// ----------------------------------------------------------------------------
// Throughput: one tick per cycle while the skid entry is empty, set by the
// single state update path; the two-entry output buffer keeps input flowing
// through an output stall until the skid entry fills. Reset (synchronous,
// active low) clears all counters, the LED and buzzer levels, every
// configuration register and both buffers.
// ----------------------------------------------------------------------------
module led_bit_pattern_sequencer
    import lbps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Configuration write port.
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,

    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] tick, [7:1] zero

    // Output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] red_led_on, [1] buzzer_on,
                                                   // [2] state_request,
                                                   // [10:3] requested_state,
                                                   // [15:11] zero
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   r_pattern;
    logic [CNT_W-1:0]   r_tick_period;
    logic [CNT_W-1:0]   r_last_bit_index;
    logic [CNT_W-1:0]   r_hold_ticks;
    logic               r_buzzer_enable;
    logic [STATE_W-1:0] r_next_state;
    logic               r_next_state_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern           <= '0;
            r_tick_period       <= '0;
            r_last_bit_index    <= '0;
            r_hold_ticks        <= '0;
            r_buzzer_enable     <= 1'b0;
            r_next_state        <= '0;
            r_next_state_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            // Indexes past the register list are ignored.
            case (t_reg_idx'(i_cfg_addr))
                REG_PATTERN:           r_pattern           <= i_cfg_wdata;
                REG_TICK_PERIOD:       r_tick_period       <= i_cfg_wdata;
                REG_LAST_BIT_INDEX:    r_last_bit_index    <= i_cfg_wdata;
                REG_HOLD_TICKS:        r_hold_ticks        <= i_cfg_wdata;
                REG_BUZZER_ENABLE:     r_buzzer_enable     <= i_cfg_wdata[0];
                REG_NEXT_STATE:        r_next_state        <= i_cfg_wdata;
                REG_NEXT_STATE_ENABLE: r_next_state_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and its single-pass update.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_tick_count, n_tick_count;
    logic [CNT_W-1:0] r_bit_index,  n_bit_index;
    logic             r_seq_done,   n_seq_done;
    logic [CNT_W-1:0] r_hold_count, n_hold_count;
    logic             r_red_level,  n_red_level;
    logic             r_buzz_level, n_buzz_level;
    t_result          w_result;

    logic             w_accept;
    logic [2:0]       w_sel;
    logic             w_pattern_bit;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_sel         = 3'(r_bit_index & BIT_SEL_MASK);
    assign w_pattern_bit = r_pattern[w_sel];

    always_comb begin
        n_tick_count = r_tick_count;
        n_bit_index  = r_bit_index;
        n_seq_done   = r_seq_done;
        n_hold_count = r_hold_count;
        n_red_level  = r_red_level;
        n_buzz_level = r_buzz_level;
        w_result.state_request   = 1'b0;
        w_result.requested_state = '0;

        if (s_axis_tdata[0]) begin
            // The prescaler always counts; the compare uses its old value.
            n_tick_count = r_tick_count + 1'b1;

            if ((r_tick_count >= r_tick_period) && !r_seq_done) begin
                n_tick_count = '0;
                if (w_pattern_bit) begin
                    n_red_level = 1'b1;
                    if (r_buzzer_enable) begin
                        n_buzz_level = 1'b1;
                    end
                end else begin
                    // A clear bit silences the buzzer regardless of enable.
                    n_red_level  = 1'b0;
                    n_buzz_level = 1'b0;
                end
                n_bit_index = r_bit_index + 1'b1;
                if (r_bit_index >= r_last_bit_index) begin
                    n_bit_index = '0;
                    n_seq_done  = 1'b1;
                end
            end

            // The hold check also runs on the tick that ends the sequence.
            if (n_seq_done) begin
                n_hold_count = r_hold_count + 1'b1;
                if (r_hold_count >= r_hold_ticks) begin
                    // The buzzer keeps its level through the restart.
                    n_red_level  = 1'b0;
                    n_seq_done   = 1'b0;
                    n_hold_count = '0;
                    n_tick_count = '0;
                    n_bit_index  = '0;
                    if (r_next_state_enable) begin
                        w_result.state_request   = 1'b1;
                        w_result.requested_state = r_next_state;
                    end
                end
            end
        end

        w_result.red_led_on = n_red_level;
        w_result.buzzer_on  = n_buzz_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_bit_index  <= '0;
            r_seq_done   <= 1'b0;
            r_hold_count <= '0;
            r_red_level  <= 1'b0;
            r_buzz_level <= 1'b0;
        end else if (w_accept) begin
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_seq_done   <= n_seq_done;
            r_hold_count <= n_hold_count;
            r_red_level  <= n_red_level;
            r_buzz_level <= n_buzz_level;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid stage. The input side stalls only when the
    // skid entry is occupied, so a stall on the output does not stop ticks
    // from being transferred in until the skid entry fills.
    // ------------------------------------------------------------------
    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;
    logic    w_out_fire;

    assign w_out_fire    = r_out_valid && m_axis_tready;
    assign s_axis_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_fire) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (w_accept) begin
                    r_out <= w_result;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (!r_out_valid) begin
                if (w_accept) begin
                    r_out       <= w_result;
                    r_out_valid <= 1'b1;
                end
            end else if (w_accept) begin
                r_skid       <= w_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The skid entry is only ever filled behind a held output entry.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output entry empty");

    // A restart request always comes with the red LED switched off.
    a_req_led_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> !m_axis_tdata[0])
        else $error("state request with red LED on");

    // Without a request the requested state reads as zero.
    a_no_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[10:3] == '0))
        else $error("requested state nonzero without request");

    // An idle tick leaves the sequencer state untouched.
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !s_axis_tdata[0]) |=>
            ($stable(r_tick_count) && $stable(r_bit_index) && $stable(r_hold_count)))
        else $error("idle tick changed sequencer state");

endmodule
